### rtl/core/scheduled_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// scheduled priority queue assertion macros
// shared property forms for the queue core checks
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SCHEDULED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants of the scheduled priority queue core
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int PRI_W       = 8;

    localparam logic [TIME_W-1:0] ALL_ONES_TIME = 32'hFFFF_FFFF;
    localparam logic [PRI_W-1:0]  NO_PRIORITY   = 8'hFF;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_TAKE   = 3'd1,
        OP_PEEK   = 3'd2,
        OP_COUNT  = 3'd3,
        OP_NEXT   = 3'd4,
        OP_REMOVE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        SCAN_PICK    = 2'd0,
        SCAN_COUNT   = 2'd1,
        SCAN_REBUILD = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [PRI_W-1:0]       pri;
        time_t                  due;
    } entry_t;

    typedef struct packed {
        logic due;
        logic earlier;
    } cmp_flags_t;

endpackage

### rtl/core/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// request channel of the queue core: operation and its arguments
// ----------------------------------------------------------------------------
interface spq_req_if;

    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  handle;
    logic [7:0]  priority_req;
    logic [31:0] time_req;
    logic [3:0]  index;

    modport source (
        output valid,
        output operation,
        output handle,
        output priority_req,
        output time_req,
        output index,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  handle,
        input  priority_req,
        input  time_req,
        input  index,
        output ready
    );

endinterface

### rtl/core/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// response channel of the queue core: one result per request
// ----------------------------------------------------------------------------
interface spq_rsp_if;

    logic        valid;
    logic        ready;
    logic        ok;
    logic [7:0]  handle_out;
    logic [4:0]  count;
    logic [31:0] time_out;

    modport source (
        output valid,
        output ok,
        output handle_out,
        output count,
        output time_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  ok,
        input  handle_out,
        input  count,
        input  time_out,
        output ready
    );

endinterface

### rtl/core/spq_entry_ram.sv
// ----------------------------------------------------------------------------
// spq_entry_ram
// entry table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module spq_entry_ram (
    input  logic            clk,
    input  logic            we,
    input  spq_pkg::idx_t   waddr,
    input  spq_pkg::entry_t wdata,
    input  spq_pkg::idx_t   raddr,
    output spq_pkg::entry_t rdata
);

    spq_pkg::entry_t mem [spq_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/spq_time_cmp.sv
// ----------------------------------------------------------------------------
// spq_time_cmp
// shared wrap-aware time comparator: one subtract, sign and zero flags
// ----------------------------------------------------------------------------
module spq_time_cmp (
    input  spq_pkg::time_t     a,
    input  spq_pkg::time_t     b,
    output spq_pkg::cmp_flags_t flags
);

    spq_pkg::time_t diff;

    assign diff = a - b;

    // a is behind b when the difference is negative; due includes equality
    assign flags.earlier = diff[spq_pkg::TIME_W-1];
    assign flags.due     = diff[spq_pkg::TIME_W-1] || (diff == '0);

endmodule

### rtl/core/scheduled_priority_queue_core.sv
// add, next time, count of all and unused codes: the result comes straight from the execute state
// take, peek and count scan: one table read per cycle over the filled part of the table
// take and remove add a shift pass that moves the slots above the removed one down, remove
// one slot read, and a rebuild scan when the earliest due entry leaves
// one request at a time; a held result stalls the report state until it is taken
// reset clears fill and earliest due; the entry table is not cleared and needs no pass
// ----------------------------------------------------------------------------
// scheduled_priority_queue_core
// time-scheduled priority queue: a sequencer walks the entry table through
// one ram read port and one shared time comparator
// ----------------------------------------------------------------------------
`include "scheduled_priority_queue_core_defines.svh"

module scheduled_priority_queue_core (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_RDSLOT = 6'b001000,
        ST_SHIFT  = 6'b010000,
        ST_REPORT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]                      op_reg, op_next;
    logic [spq_pkg::HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [spq_pkg::PRI_W-1:0]       pri_reg, pri_next;
    spq_pkg::time_t                  time_reg, time_next;
    logic [3:0]                      idx_reg, idx_next;

    spq_pkg::fill_t      fill_reg, fill_next;
    spq_pkg::time_t      earliest_reg, earliest_next;
    spq_pkg::fill_t      issue_ptr_reg, issue_ptr_next;
    logic                pend_valid_reg, pend_valid_next;
    spq_pkg::idx_t       pend_ptr_reg, pend_ptr_next;
    spq_pkg::scan_mode_t mode_reg, mode_next;

    logic [spq_pkg::PRI_W-1:0] best_pri_reg, best_pri_next;
    spq_pkg::idx_t             best_idx_reg, best_idx_next;
    spq_pkg::time_t            gone_due_reg, gone_due_next;

    logic                            res_ok_reg, res_ok_next;
    logic [spq_pkg::HANDLE_BITS-1:0] res_handle_reg, res_handle_next;
    spq_pkg::fill_t                  res_count_reg, res_count_next;
    spq_pkg::time_t                  res_time_reg, res_time_next;

    logic           rsp_valid_reg, rsp_valid_next;
    logic           rsp_ok_reg, rsp_ok_next;
    logic [7:0]     rsp_handle_reg, rsp_handle_next;
    logic [4:0]     rsp_count_reg, rsp_count_next;
    spq_pkg::time_t rsp_time_reg, rsp_time_next;

    logic                ram_we;
    spq_pkg::idx_t       ram_waddr;
    spq_pkg::entry_t     ram_wdata;
    spq_pkg::idx_t       ram_raddr;
    spq_pkg::entry_t     ram_rdata;
    spq_pkg::time_t      cmp_a;
    spq_pkg::time_t      cmp_b;
    spq_pkg::cmp_flags_t cmp_flags;
    logic                issue_more;

    spq_entry_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spq_time_cmp u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .flags (cmp_flags)
    );

    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = rsp_ok_reg;
    assign rsp.handle_out = rsp_handle_reg;
    assign rsp.count      = rsp_count_reg;
    assign rsp.time_out   = rsp_time_reg;

    assign issue_more = (issue_ptr_reg < fill_reg);

    // comparator operand selection
    always_comb
    begin
        if (state_reg == ST_EXEC)
        begin
            cmp_a = (op_reg == spq_pkg::OP_ADD) ? time_reg : earliest_reg;
        end
        else
        begin
            cmp_a = ram_rdata.due;
        end
        if (((state_reg == ST_EXEC) && (op_reg == spq_pkg::OP_ADD)) ||
            ((state_reg == ST_SCAN) && (mode_reg == spq_pkg::SCAN_REBUILD)))
        begin
            cmp_b = earliest_reg;
        end
        else
        begin
            cmp_b = time_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        handle_next     = handle_reg;
        pri_next        = pri_reg;
        time_next       = time_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        earliest_next   = earliest_reg;
        issue_ptr_next  = issue_ptr_reg;
        pend_valid_next = 1'b0;
        pend_ptr_next   = pend_ptr_reg;
        mode_next       = mode_reg;
        best_pri_next   = best_pri_reg;
        best_idx_next   = best_idx_reg;
        gone_due_next   = gone_due_reg;
        res_ok_next     = res_ok_reg;
        res_handle_next = res_handle_reg;
        res_count_next  = res_count_reg;
        res_time_next   = res_time_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_ok_next     = rsp_ok_reg;
        rsp_handle_next = rsp_handle_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_time_next   = rsp_time_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_ptr_reg - spq_pkg::idx_t'(1);
        ram_wdata       = ram_rdata;
        ram_raddr       = issue_ptr_reg[spq_pkg::IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.operation;
                    handle_next = req.handle[spq_pkg::HANDLE_BITS-1:0];
                    pri_next    = req.priority_req;
                    time_next   = req.time_req;
                    idx_next    = req.index;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_ok_next     = 1'b0;
                res_handle_next = '0;
                res_count_next  = '0;
                res_time_next   = '0;
                state_next      = ST_REPORT;
                case (op_reg)
                    spq_pkg::OP_ADD:
                    begin
                        if (fill_reg < spq_pkg::fill_t'(spq_pkg::QUEUE_DEPTH))
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = fill_reg[spq_pkg::IDX_W-1:0];
                            ram_wdata.handle = handle_reg;
                            ram_wdata.pri    = pri_reg;
                            ram_wdata.due    = time_reg;
                            if ((fill_reg == '0) || cmp_flags.earlier)
                            begin
                                earliest_next = time_reg;
                            end
                            fill_next   = fill_reg + spq_pkg::fill_t'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    spq_pkg::OP_TAKE, spq_pkg::OP_PEEK:
                    begin
                        best_pri_next  = spq_pkg::NO_PRIORITY;
                        issue_ptr_next = '0;
                        mode_next      = spq_pkg::SCAN_PICK;
                        state_next     = ST_SCAN;
                    end
                    spq_pkg::OP_COUNT:
                    begin
                        if (time_reg == spq_pkg::ALL_ONES_TIME)
                        begin
                            res_count_next = fill_reg;
                            res_ok_next    = 1'b1;
                        end
                        else
                        begin
                            issue_ptr_next = '0;
                            mode_next      = spq_pkg::SCAN_COUNT;
                            state_next     = ST_SCAN;
                        end
                    end
                    spq_pkg::OP_NEXT:
                    begin
                        if (fill_reg != '0)
                        begin
                            res_ok_next   = 1'b1;
                            res_time_next = cmp_flags.due ? time_reg : earliest_reg;
                        end
                    end
                    spq_pkg::OP_REMOVE:
                    begin
                        if (spq_pkg::fill_t'(idx_reg) < fill_reg)
                        begin
                            ram_raddr  = idx_reg[spq_pkg::IDX_W-1:0];
                            state_next = ST_RDSLOT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_REPORT;
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (issue_more)
                begin
                    issue_ptr_next  = issue_ptr_reg + spq_pkg::fill_t'(1);
                    pend_valid_next = 1'b1;
                    pend_ptr_next   = issue_ptr_reg[spq_pkg::IDX_W-1:0];
                end
                if (pend_valid_reg)
                begin
                    case (mode_reg)
                        spq_pkg::SCAN_PICK:
                        begin
                            if (cmp_flags.due && (ram_rdata.pri < best_pri_reg))
                            begin
                                best_pri_next   = ram_rdata.pri;
                                best_idx_next   = pend_ptr_reg;
                                res_handle_next = ram_rdata.handle;
                                gone_due_next   = ram_rdata.due;
                            end
                        end
                        spq_pkg::SCAN_COUNT:
                        begin
                            if (cmp_flags.due)
                            begin
                                res_count_next = res_count_reg + spq_pkg::fill_t'(1);
                            end
                        end
                        spq_pkg::SCAN_REBUILD:
                        begin
                            if ((pend_ptr_reg == '0) || cmp_flags.earlier)
                            begin
                                earliest_next = ram_rdata.due;
                            end
                        end
                        default:
                        begin
                            earliest_next = earliest_reg;
                        end
                    endcase
                end
                else if (!issue_more)
                begin
                    state_next = ST_REPORT;
                    case (mode_reg)
                        spq_pkg::SCAN_PICK:
                        begin
                            if (best_pri_reg != spq_pkg::NO_PRIORITY)
                            begin
                                res_ok_next = 1'b1;
                                if (op_reg == spq_pkg::OP_TAKE)
                                begin
                                    issue_ptr_next = spq_pkg::fill_t'(best_idx_reg)
                                                     + spq_pkg::fill_t'(1);
                                    state_next     = ST_SHIFT;
                                end
                            end
                        end
                        spq_pkg::SCAN_COUNT:
                        begin
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = res_ok_reg;
                        end
                    endcase
                end
            end

            ST_RDSLOT:
            begin
                res_handle_next = ram_rdata.handle;
                gone_due_next   = ram_rdata.due;
                res_ok_next     = 1'b1;
                issue_ptr_next  = spq_pkg::fill_t'(idx_reg) + spq_pkg::fill_t'(1);
                state_next      = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                // read slot k+1 and write it back one slot down
                if (issue_more)
                begin
                    issue_ptr_next  = issue_ptr_reg + spq_pkg::fill_t'(1);
                    pend_valid_next = 1'b1;
                    pend_ptr_next   = issue_ptr_reg[spq_pkg::IDX_W-1:0];
                end
                if (pend_valid_reg)
                begin
                    ram_we = 1'b1;
                end
                else if (!issue_more)
                begin
                    fill_next  = fill_reg - spq_pkg::fill_t'(1);
                    state_next = ST_REPORT;
                    if (fill_reg == spq_pkg::fill_t'(1))
                    begin
                        earliest_next = '0;
                    end
                    else if (gone_due_reg == earliest_reg)
                    begin
                        issue_ptr_next = '0;
                        mode_next      = spq_pkg::SCAN_REBUILD;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_REPORT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_ok_next     = res_ok_reg;
                    rsp_handle_next = 8'(res_handle_reg);
                    rsp_count_next  = 5'(res_count_reg);
                    rsp_time_next   = res_time_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            earliest_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            earliest_reg   <= earliest_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        handle_reg     <= handle_next;
        pri_reg        <= pri_next;
        time_reg       <= time_next;
        idx_reg        <= idx_next;
        issue_ptr_reg  <= issue_ptr_next;
        pend_ptr_reg   <= pend_ptr_next;
        mode_reg       <= mode_next;
        best_pri_reg   <= best_pri_next;
        best_idx_reg   <= best_idx_next;
        gone_due_reg   <= gone_due_next;
        res_ok_reg     <= res_ok_next;
        res_handle_reg <= res_handle_next;
        res_count_reg  <= res_count_next;
        res_time_reg   <= res_time_next;
        rsp_ok_reg     <= rsp_ok_next;
        rsp_handle_reg <= rsp_handle_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_time_reg   <= rsp_time_next;
    end

    // table never grows past its depth
    `SPQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= spq_pkg::fill_t'(spq_pkg::QUEUE_DEPTH))

    // a request transfer always starts execution in the next cycle
    `SPQ_ASSERT_NEXT(a_req_to_exec, req.valid && req.ready, state_reg == ST_EXEC)

    // table size only moves while a request is being worked on
    `SPQ_ASSERT_NEXT(a_fill_idle, state_reg == ST_IDLE, fill_reg == $past(fill_reg))

    // shift writes stay inside the occupied part of the table
    `SPQ_ASSERT_SAME(a_shift_in_range, ram_we && (state_reg == ST_SHIFT),
                     spq_pkg::fill_t'(ram_waddr) < fill_reg)

endmodule
